>>> src/pcgbs_pkg.sv
// ----------------------------------------------------------------------------
// pcgbs_pkg
// Shared constants, types and the output permutation of the bounded sampler.
// ----------------------------------------------------------------------------
package pcgbs_pkg;

    localparam int unsigned STATE_W  = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned SEQ_W    = 63;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [STATE_W-1:0] LCG_MULT   = 64'd6364136223846793005;
    localparam logic [HALF_W-1:0]  MULT_LO    = LCG_MULT[31:0];
    localparam logic [HALF_W-1:0]  MULT_HI    = LCG_MULT[63:32];
    // state after seeding with both seeds at zero: 1 * mult + 1
    localparam logic [STATE_W-1:0] SEED_RESET = LCG_MULT + 64'd1;

    localparam int unsigned XSH_SHIFT = 18;
    localparam int unsigned XSH_DROP  = 27;
    localparam int unsigned ROT_POS   = 59;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_STATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQUENCE = 2'd1;

    typedef struct packed {
        logic cfg_write;
        logic seed_add;
        logic bounds_load;
        logic draw_cap;
        logic state_adv;
        logic mod_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic span_full;
        logic low_ge_span;
        logic low_ge_thr;
        logic thr_valid;
        logic out_free;
        logic mod_busy;
        logic mod_done;
    } status_t;

    function automatic logic [HALF_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
        logic [STATE_W-1:0] mixed;
        logic [HALF_W-1:0]  xs;
        logic [4:0]         rot;
        mixed = ((old >> XSH_SHIFT) ^ old) >> XSH_DROP;
        xs    = mixed[HALF_W-1:0];
        rot   = old[ROT_POS+4:ROT_POS];
        return (xs >> rot) | (xs << (5'd0 - rot));
    endfunction

endpackage

>>> src/pcg32_bounded_uniform_sampler.sv
// ----------------------------------------------------------------------------
// pcg32_bounded_uniform_sampler
// PCG32 XSH-RR generator returning one uniform value per bounds request.
// ----------------------------------------------------------------------------
// Each request carries two inclusive signed bounds (either order) and returns
// one uniform sample between them. For each draw, one state forms the draw
// and the four 32x32 products and a second advances the 64-bit state and
// decides; when a kept draw finds the result register free, the next request
// is taken in that deciding state. A rejected draw repeats both. The first
// time in a request that a draw's low product word falls below the span, the
// threshold (2^32 - span) mod span is built by a bit-serial remainder unit.
// A write to init_state or init_sequence reseeds the generator through add,
// multiply and advance states, in which no request is taken; a write to any
// other index is ignored. After reset the generator holds the seeded state.
// ----------------------------------------------------------------------------
module pcg32_bounded_uniform_sampler (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // lower_bound, upper_bound
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // sample
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcgbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                      cfg_data
);

    pcgbs_pkg::cmd_t    cmd;
    pcgbs_pkg::status_t status;

    pcgbs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pcgbs_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

>>> src/pcgbs_mod.sv
// ----------------------------------------------------------------------------
// pcgbs_mod
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcgbs_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pcgbs_pkg::HALF_W-1:0]  dividend,
    input  logic [pcgbs_pkg::HALF_W-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic [pcgbs_pkg::HALF_W-1:0]  remainder
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [pcgbs_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [pcgbs_pkg::HALF_W-1:0]    rem_reg, rem_next;
    logic [pcgbs_pkg::HALF_W-1:0]    dvd_reg, dvd_next;
    logic [pcgbs_pkg::HALF_W:0]      trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        trial     = {rem_reg, dvd_reg[pcgbs_pkg::HALF_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = pcgbs_pkg::HALF_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[pcgbs_pkg::HALF_W-1:0];
            end
            dvd_next = {dvd_reg[pcgbs_pkg::HALF_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pcgbs_pkg::DIV_CNT_W'(pcgbs_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> src/pcgbs_dpath.sv
// ----------------------------------------------------------------------------
// pcgbs_dpath
// Generator state, seed registers, bounds, multipliers, remainder unit and result register.
// ----------------------------------------------------------------------------
module pcgbs_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pcgbs_pkg::cmd_t                  cmd,
    output pcgbs_pkg::status_t               status,
    input  logic [63:0]                      s_tdata,   // lower_bound, upper_bound
    input  logic [pcgbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [31:0]                      m_tdata    // sample
);

    logic [pcgbs_pkg::STATE_W-1:0] state_reg, state_next;
    logic [pcgbs_pkg::STATE_W-1:0] init_state_reg;
    logic [pcgbs_pkg::SEQ_W-1:0]   init_seq_reg;
    logic [pcgbs_pkg::STATE_W-1:0] inc;

    logic [31:0] lo_reg, span_reg;
    logic [31:0] draw_reg;
    logic [63:0] prod_reg;
    logic [63:0] pp0_reg;
    logic [31:0] x1_reg, x2_reg;
    logic [31:0] thr_reg;
    logic        thr_valid_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic [31:0] in_lo, in_hi;
    logic        swap;
    logic [31:0] draw_now;
    logic [31:0] adv_hi;
    logic [31:0] result;

    logic        mod_busy, mod_done;
    logic [31:0] mod_rem;

    assign inc   = {init_seq_reg, 1'b1};
    assign in_lo = s_tdata[31:0];
    assign in_hi = s_tdata[63:32];
    assign swap  = $signed(in_hi) < $signed(in_lo);

    assign draw_now = pcgbs_pkg::xsh_rr(state_reg);
    // upper half of state * mult, low 64 bits kept
    assign adv_hi   = pp0_reg[63:32] + x1_reg + x2_reg;

    always_comb begin
        state_next = state_reg;
        if (cmd.seed_add) begin
            state_next = inc + init_state_reg;
        end else if (cmd.state_adv) begin
            state_next = {adv_hi, pp0_reg[31:0]} + inc;
        end
    end

    assign result = status.span_full ? (draw_reg + lo_reg) : (prod_reg[63:32] + lo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pcgbs_pkg::SEED_RESET;
            init_state_reg <= '0;
            init_seq_reg   <= '0;
            thr_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.cfg_write) begin
                if (cfg_index == pcgbs_pkg::REG_INIT_STATE) begin
                    init_state_reg <= cfg_data;
                end else if (cfg_index == pcgbs_pkg::REG_INIT_SEQUENCE) begin
                    init_seq_reg <= cfg_data[pcgbs_pkg::SEQ_W-1:0];
                end
            end
            if (cmd.bounds_load) begin
                thr_valid_reg <= 1'b0;
            end else if (mod_done) begin
                thr_valid_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.bounds_load) begin
            lo_reg   <= swap ? in_hi : in_lo;
            span_reg <= swap ? (in_lo - in_hi + 32'd1) : (in_hi - in_lo + 32'd1);
        end
        if (cmd.draw_cap) begin
            draw_reg <= draw_now;
            prod_reg <= draw_now * span_reg;
            pp0_reg  <= state_reg[31:0] * pcgbs_pkg::MULT_LO;
            x1_reg   <= 32'(state_reg[63:32] * pcgbs_pkg::MULT_LO);
            x2_reg   <= 32'(state_reg[31:0] * pcgbs_pkg::MULT_HI);
        end
        if (mod_done) begin
            thr_reg <= mod_rem;
        end
        if (cmd.out_load) begin
            out_data_reg <= result;
        end
    end

    // rejection threshold (2^32 - span) mod span
    pcgbs_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (32'd0 - span_reg),
        .divisor   (span_reg),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        status.span_full   = (span_reg == 32'd0);
        status.low_ge_span = (prod_reg[31:0] >= span_reg);
        status.low_ge_thr  = (prod_reg[31:0] >= thr_reg);
        status.thr_valid   = thr_valid_reg;
        status.out_free    = !out_valid_reg || m_tready;
        status.mod_busy    = mod_busy;
        status.mod_done    = mod_done;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> src/pcgbs_ctrl.sv
// ----------------------------------------------------------------------------
// pcgbs_ctrl
// Sequencer for seeding, drawing, rejection and result hand-off.
// ----------------------------------------------------------------------------
module pcgbs_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             cfg_valid,
    input  logic [pcgbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    output logic                             cfg_ready,
    input  pcgbs_pkg::status_t               status,
    output pcgbs_pkg::cmd_t                  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_ADD,
        S_SEED_MUL,
        S_SEED_ADV,
        S_DRAW,
        S_CHECK,
        S_DIV,
        S_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   hold_reg, hold_next;
    logic   cfg_hit;
    logic   take;
    logic   finish;

    assign cfg_hit = (cfg_index == pcgbs_pkg::REG_INIT_STATE) ||
                     (cfg_index == pcgbs_pkg::REG_INIT_SEQUENCE);

    always_comb begin
        state_next = state_reg;
        hold_next  = hold_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        take       = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
                if (cfg_valid) begin
                    cmd.cfg_write = 1'b1;
                    if (cfg_hit) begin
                        state_next = S_SEED_ADD;
                    end
                end else if (s_tvalid) begin
                    cmd.bounds_load = 1'b1;
                    state_next      = S_DRAW;
                end
            end
            S_SEED_ADD: begin
                cmd.seed_add = 1'b1;
                state_next   = S_SEED_MUL;
            end
            S_SEED_MUL: begin
                cmd.draw_cap = 1'b1;
                state_next   = S_SEED_ADV;
            end
            S_SEED_ADV: begin
                cmd.state_adv = 1'b1;
                state_next    = S_IDLE;
            end
            S_DRAW: begin
                cmd.draw_cap = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                cmd.state_adv = 1'b1;
                take = status.span_full || status.low_ge_span ||
                       (status.thr_valid && status.low_ge_thr);
                if (take) begin
                    if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        finish       = 1'b1;
                    end else begin
                        // result stays in the product registers until taken
                        hold_next  = 1'b1;
                        state_next = S_EVAL;
                    end
                end else if (status.thr_valid) begin
                    state_next = S_DRAW;
                end else begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (status.mod_done) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                take = hold_reg || status.low_ge_thr;
                if (take) begin
                    if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        finish       = 1'b1;
                    end else begin
                        hold_next = 1'b1;
                    end
                end else begin
                    state_next = S_DRAW;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (finish) begin
            hold_next = 1'b0;
            // next request goes straight into its draw
            s_tready  = 1'b1;
            if (s_tvalid) begin
                cmd.bounds_load = 1'b1;
                state_next      = S_DRAW;
            end else begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hold_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
        end
    end

    a_cfg_req_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_ready && s_tvalid && s_tready))
        else $error("config write and request taken in the same cycle");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result register loaded while still held");

    a_mod_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_start |=> status.mod_busy)
        else $error("remainder unit did not start");

    a_draw_then_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_cap |=> cmd.state_adv)
        else $error("draw not followed by a state advance");

endmodule

>>> test/tb_pcg32_bounded_uniform_sampler.sv
// ----------------------------------------------------------------------------
// tb_pcg32_bounded_uniform_sampler
// Self-checking bench for the bounded uniform sampler.
// ----------------------------------------------------------------------------
// A scoreboard holds its own copy of the generator state and both seed
// registers. For every bounds request it predicts the sample, redraws
// included, and every sample that leaves the block is checked in order.
// The run covers a directed set of corner bounds on the reset seeds and then
// random bounds under several seed settings. Both sides insert random gaps,
// and the receiver stalls for a long stretch now and then.
// ----------------------------------------------------------------------------
module tb_pcg32_bounded_uniform_sampler;

    localparam int unsigned  CLK_HALF        = 6;
    localparam int unsigned  RESET_CYCLES    = 9;
    localparam int unsigned  WATCHDOG_LIMIT  = 4000;
    localparam int unsigned  TAIL_CYCLES     = 60;
    localparam int unsigned  LONG_HOLD       = 180;
    localparam int unsigned  SEED_PHASES     = 6;
    localparam int unsigned  ITEMS_PER_PHASE = 230;
    localparam int unsigned  N_DIRECTED      = 21;

    // indexes that map to no register
    localparam logic [pcgbs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [pcgbs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // corner bounds, packed as {upper, lower}
    localparam bit [63:0] DIRECTED_BOUNDS [N_DIRECTED] = '{
        {32'h7FFF_FFFF, 32'h8000_0000},  // full range
        {32'h8000_0000, 32'h7FFF_FFFF},  // full range, reversed
        {32'h8000_0000, 32'h8000_0000},
        {32'h7FFF_FFFF, 32'h7FFF_FFFF},
        {32'h0000_0000, 32'h0000_0000},
        {32'h0000_0000, 32'hFFFF_FFFF},
        {32'hFFFF_FFF6, 32'h0000_000A},  // reversed small range
        {32'h0000_0000, 32'h8000_0000},  // span just above half, many redraws
        {32'h8000_0000, 32'h0000_0000},
        {32'h4000_0000, 32'hC000_0000},
        {32'h7FFF_FFFF, 32'h8000_0001},  // span 2^32 - 1
        {32'h7FFF_FFFE, 32'h8000_0000},
        {32'h0000_0002, 32'h0000_0000},
        {32'h0000_0000, 32'h0000_0001},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'h7FFF_FFFF, 32'h0000_0000},  // span 2^31
        {32'hFFFF_FFFF, 32'h8000_0000},
        {32'h0000_0001, 32'h8000_0000},
        {32'h5555_5555, 32'hAAAA_AAAA},
        {32'hAAAA_AAAA, 32'h5555_5555},
        {32'h0001_0000, 32'hFFFF_0000}
    };

    class sampler_scoreboard;
        localparam bit [63:0] PCG_MULT = 64'd6364136223846793005;

        bit [63:0]   seed_offset;
        bit [62:0]   stream_sel;
        bit [63:0]   lcg_state;
        logic [31:0] pending_samples[$];
        int          mismatches;
        int          samples_checked;
        int          redraws;
        int          full_spans;

        function bit [31:0] next_draw();
            bit [63:0] old;
            bit [63:0] mix;
            bit [31:0] xs;
            bit [63:0] twin;
            old       = lcg_state;
            lcg_state = old * PCG_MULT + {stream_sel, 1'b1};
            mix       = ((old >> 18) ^ old) >> 27;
            xs        = mix[31:0];
            // rotate right by the top five state bits
            twin      = {xs, xs} >> old[63:59];
            return twin[31:0];
        endfunction

        function void reseed();
            bit [31:0] discard;
            lcg_state = 64'd0;
            discard   = next_draw();
            lcg_state = lcg_state + seed_offset;
            discard   = next_draw();
        endfunction

        function void load_reset_seeds();
            seed_offset = 64'd0;
            stream_sel  = 63'd0;
            reseed();
        endfunction

        function void write_reg(logic [pcgbs_pkg::CFG_IDX_W-1:0] idx, bit [63:0] value);
            case (idx)
                pcgbs_pkg::REG_INIT_STATE: begin
                    seed_offset = value;
                    reseed();
                end
                pcgbs_pkg::REG_INIT_SEQUENCE: begin
                    stream_sel = value[62:0];
                    reseed();
                end
                default: ;
            endcase
        endfunction

        function void note_request(bit [63:0] bounds);
            bit [31:0] lo;
            bit [31:0] hi;
            bit [31:0] span;
            bit [31:0] thr;
            bit [31:0] result;
            bit [63:0] prod;
            bit        kept;
            lo = bounds[31:0];
            hi = bounds[63:32];
            if ($signed(hi) < $signed(lo)) begin
                lo = bounds[63:32];
                hi = bounds[31:0];
            end
            span = hi - lo + 32'd1;
            if (span == 32'd0) begin
                full_spans++;
                result = next_draw() + lo;
            end else begin
                thr  = (32'd0 - span) % span;
                kept = 1'b0;
                while (!kept) begin
                    prod = {32'd0, next_draw()} * {32'd0, span};
                    if (prod[31:0] >= thr) begin
                        kept   = 1'b1;
                        result = prod[63:32] + lo;
                    end else begin
                        redraws++;
                    end
                end
            end
            pending_samples.push_back(result);
        endfunction

        function void check_sample(logic [31:0] got);
            logic [31:0] want;
            if (pending_samples.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected sample %h with no request pending", $time, got);
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: sample mismatch, expected %h, got %h", $time, want, got);
                end
            end
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [63:0]                         s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [31:0]                         m_tdata;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [pcgbs_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [63:0]                         cfg_data;

    sampler_scoreboard sb;
    int                requests_sent;
    int                seed_settings;
    int                send_burst;
    int                recv_burst;
    int                quiet_cycles;

    pcg32_bounded_uniform_sampler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // gap before the next request or sample, with occasional back-to-back runs
    function automatic int idle_cycles(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic bit [63:0] random_bounds();
        bit [31:0]   lo;
        bit [31:0]   hi;
        bit [31:0]   span;
        bit [32:0]   room;
        bit [32:0]   pos;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    span = $urandom_range(1, 16);
            2:       span = $urandom_range(17, 65536);
            3, 4:    span = $urandom;
            5:       span = 32'h8000_0000 + $urandom_range(1, 4096);
            6:       span = 32'hFFFF_FFFF - $urandom_range(0, 7);
            7:       span = 32'd0;
            8:       span = 32'd1;
            default: return {$urandom, $urandom};
        endcase
        if (span == 32'd0) begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
        end else begin
            // place the range anywhere it fits without wrapping
            room = 33'h1_0000_0000 - {1'b0, span} + 33'd1;
            pos  = {1'b0, $urandom} % room;
            lo   = 32'h8000_0000 + pos[31:0];
            hi   = lo + span - 32'd1;
        end
        if ($urandom_range(0, 1)) begin
            return {lo, hi};
        end
        return {hi, lo};
    endfunction

    task automatic write_cfg(input logic [pcgbs_pkg::CFG_IDX_W-1:0] idx,
                             input bit [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_bounds(input bit [63:0] bounds);
        int gap;
        gap = idle_cycles(send_burst);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = bounds;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(bounds);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_samples();
        s_tvalid = 1'b0;
        while (sb.pending_samples.size() != 0) @(negedge aclk);
    endtask

    // receiver: random gaps per sample, two long holds to back up the block
    initial begin
        int gap;
        int holds_done;
        holds_done = 0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = idle_cycles(recv_burst);
            if ((holds_done == 0 && sb.samples_checked >= 200) ||
                (holds_done == 1 && sb.samples_checked >= 900)) begin
                gap = LONG_HOLD;
                holds_done++;
            end
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_sample(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        bit [63:0] st;
        bit [63:0] sq;
        quiet_cycles  = 0;
        requests_sent = 0;
        seed_settings = 1;
        send_burst    = 0;
        recv_burst    = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = pcgbs_pkg::REG_INIT_STATE;
        cfg_data      = '0;
        sb = new;
        sb.load_reset_seeds();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // corner bounds on the seeds left by reset
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_bounds(DIRECTED_BOUNDS[i]);
        end
        drain_samples();

        for (int phase = 0; phase < SEED_PHASES; phase++) begin
            case (phase)
                0: begin
                    st = '1;
                    sq = '1;  // top bit is dropped by the register
                end
                1: begin
                    st = '0;
                    sq = '0;
                end
                2: begin
                    st = 64'h8000_0000_0000_0000;
                    sq = 64'h7FFF_FFFF_FFFF_FFFF;
                end
                3: begin
                    st = 64'd1;
                    sq = 64'd1;
                end
                default: begin
                    st = {$urandom, $urandom};
                    sq = {$urandom, $urandom};
                end
            endcase
            // writes to unmapped indexes must not disturb the generator
            write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      {$urandom, $urandom});
            if ($urandom_range(0, 1)) begin
                write_cfg(pcgbs_pkg::REG_INIT_STATE, st);
                write_cfg(pcgbs_pkg::REG_INIT_SEQUENCE, sq);
            end else begin
                write_cfg(pcgbs_pkg::REG_INIT_SEQUENCE, sq);
                write_cfg(pcgbs_pkg::REG_INIT_STATE, st);
            end
            seed_settings++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_bounds(random_bounds());
            end
            drain_samples();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("covered %0d bound requests under %0d seed settings", requests_sent,
                 seed_settings);
        $display("%0d samples compared, %0d full-range draws, %0d redraws predicted",
                 sb.samples_checked, sb.full_spans, sb.redraws);
        if (sb.mismatches == 0 && sb.pending_samples.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
